@@ sv/dsa_pkg.sv @@
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int unsigned MAX_INTERVALS = 256;
  localparam int unsigned ADDR_W = $clog2(MAX_INTERVALS);
  localparam int unsigned CNT_W  = $clog2(MAX_INTERVALS + 1);

  localparam int unsigned LIMIT_W  = 40;
  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned SPEED_W  = 32;
  localparam int unsigned SLOT_W   = 40;
  localparam int unsigned END_W    = SLOT_W + 1;
  localparam int unsigned STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FAILED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic              first;
    logic              over;
    logic [SLOT_W-1:0] deadline;
  } job_t;

  // One occupied interval [istart, iend).
  typedef struct packed {
    logic [END_W-1:0]  iend;
    logic [SLOT_W-1:0] istart;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

@@ sv/dsa_ram.sv @@
`timescale 1ns / 1ps

module dsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/dsa_front.sv @@
`timescale 1ns / 1ps

module dsa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [dsa_pkg::LIMIT_W-1:0]      limit_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             first_i,
  input  logic [dsa_pkg::HEIGHT_W-1:0]     height_i,
  input  logic [dsa_pkg::SPEED_W-1:0]      speed_i,
  output logic                             job_valid_o,
  input  logic                             job_ready_i,
  output dsa_pkg::job_t                    job_o
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_e;

  localparam int unsigned STEP_W = $clog2(dsa_pkg::SLOT_W + 1);

  fstate_e                       state_q;
  logic [STEP_W-1:0]             step_q;
  logic [dsa_pkg::SPEED_W-1:0]   div_q;
  logic [dsa_pkg::SPEED_W-1:0]   rem_q;
  logic [dsa_pkg::SLOT_W-1:0]    quo_q;
  logic                          first_q;
  logic                          over_q;

  logic [dsa_pkg::SPEED_W:0]     trial;
  logic                          fits;
  logic [dsa_pkg::SPEED_W:0]     trial_sub;

  // One quotient bit per cycle, restoring.
  assign trial     = {rem_q, quo_q[dsa_pkg::SLOT_W-1]};
  assign fits      = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};

  assign in_ready_o  = (state_q == F_IDLE);
  assign job_valid_o = (state_q == F_PUSH);
  assign job_o       = '{first: first_q, over: over_q, deadline: quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
      div_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      first_q <= 1'b0;
      over_q  <= 1'b0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            first_q <= first_i;
            over_q  <= {{(dsa_pkg::LIMIT_W-dsa_pkg::HEIGHT_W){1'b0}}, height_i} > limit_i;
            quo_q   <= limit_i - {{(dsa_pkg::LIMIT_W-dsa_pkg::HEIGHT_W){1'b0}}, height_i};
            div_q   <= (speed_i == '0) ? dsa_pkg::SPEED_W'(1) : speed_i;
            rem_q   <= '0;
            step_q  <= STEP_W'(dsa_pkg::SLOT_W);
            if ({{(dsa_pkg::LIMIT_W-dsa_pkg::HEIGHT_W){1'b0}}, height_i} > limit_i) begin
              state_q <= F_PUSH;
            end else begin
              state_q <= F_DIV;
            end
          end
        end
        F_DIV: begin
          rem_q  <= fits ? trial_sub[dsa_pkg::SPEED_W-1:0] : trial[dsa_pkg::SPEED_W-1:0];
          quo_q  <= {quo_q[dsa_pkg::SLOT_W-2:0], fits};
          step_q <= step_q - STEP_W'(1);
          if (step_q == STEP_W'(1)) begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

@@ sv/dsa_queue.sv @@
`timescale 1ns / 1ps

module dsa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dsa_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dsa_pkg::job_t pop_job_o
);

  dsa_pkg::job_t slot_q [2];
  logic          wptr_q;
  logic          rptr_q;
  logic [1:0]    fill_q;
  logic          do_push;
  logic          do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_job_o    = slot_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

@@ sv/dsa_back.sv @@
`timescale 1ns / 1ps

module dsa_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  output logic                            job_ready_o,
  input  dsa_pkg::job_t                   job_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dsa_pkg::STATUS_W-1:0]    out_status_o,
  output logic [dsa_pkg::SLOT_W-1:0]      out_slot_o
);

  typedef enum logic [3:0] {
    B_IDLE, B_SCAN, B_CMP, B_DECIDE, B_SD_RD, B_SD_WR, B_SU_RD, B_SU_WR, B_RESULT
  } bstate_e;

  localparam int unsigned AW = dsa_pkg::ADDR_W;
  localparam int unsigned CW = dsa_pkg::CNT_W;
  localparam int unsigned SW = dsa_pkg::SLOT_W;
  localparam int unsigned EW = dsa_pkg::END_W;

  bstate_e                      state_q;
  logic [CW-1:0]                count_q;
  logic                         failed_q;
  logic [CW-1:0]                idx_q;
  logic [CW-1:0]                j_q;
  logic [SW-1:0]                target_q;
  logic                         second_q;
  logic                         prev_valid_q;
  dsa_pkg::entry_t              prev_q;
  logic                         next_valid_q;
  dsa_pkg::entry_t              next_q;
  logic [dsa_pkg::STATUS_W-1:0] res_status_q;
  logic [SW-1:0]                res_slot_q;
  logic                         out_valid_q;
  logic [dsa_pkg::STATUS_W-1:0] out_status_q;
  logic [SW-1:0]                out_slot_q;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  dsa_pkg::entry_t              ram_wdata;
  logic [AW-1:0]                ram_raddr;
  dsa_pkg::entry_t              ram_rdata;
  logic [dsa_pkg::ENTRY_W-1:0]  ram_rbits;

  logic [EW-1:0]                p_plus1;
  logic [CW-1:0]                idx_m1;
  logic                         covered;
  logic                         left;
  logic                         right;
  logic                         out_load;

  assign ram_rdata = dsa_pkg::entry_t'(ram_rbits);
  assign p_plus1   = {1'b0, target_q} + EW'(1);
  assign idx_m1    = idx_q - CW'(1);
  assign covered   = prev_valid_q && (prev_q.iend > {1'b0, target_q});
  assign left      = prev_valid_q && (prev_q.iend == {1'b0, target_q});
  assign right     = next_valid_q && ({1'b0, next_q.istart} == p_plus1);
  assign out_load  = (state_q == B_RESULT) && (!out_valid_q || out_ready_i);

  assign job_ready_o  = (state_q == B_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;

  // Table port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[AW-1:0];
    case (state_q)
      B_SD_RD: ram_raddr = AW'(j_q + CW'(1));
      B_SU_RD: ram_raddr = AW'(j_q - CW'(1));
      B_SD_WR, B_SU_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[AW-1:0];
        ram_wdata = ram_rdata;
      end
      B_DECIDE: begin
        if (!(!second_q && covered)) begin
          if (left && right) begin
            ram_we    = 1'b1;
            ram_waddr = idx_m1[AW-1:0];
            ram_wdata = '{iend: next_q.iend, istart: prev_q.istart};
          end else if (left) begin
            ram_we    = 1'b1;
            ram_waddr = idx_m1[AW-1:0];
            ram_wdata = '{iend: p_plus1, istart: prev_q.istart};
          end else if (right) begin
            ram_we    = 1'b1;
            ram_waddr = idx_q[AW-1:0];
            ram_wdata = '{iend: next_q.iend, istart: target_q};
          end
        end
      end
      default: ;
    endcase
    if (state_q == B_SU_RD && j_q == idx_q) begin
      ram_we    = 1'b1;
      ram_waddr = idx_q[AW-1:0];
      ram_wdata = '{iend: p_plus1, istart: target_q};
    end
  end

  dsa_ram #(
    .WIDTH(dsa_pkg::ENTRY_W),
    .DEPTH(dsa_pkg::MAX_INTERVALS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rbits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      count_q      <= '0;
      failed_q     <= 1'b0;
      idx_q        <= '0;
      j_q          <= '0;
      target_q     <= '0;
      second_q     <= 1'b0;
      prev_valid_q <= 1'b0;
      prev_q       <= '0;
      next_valid_q <= 1'b0;
      next_q       <= '0;
      res_status_q <= dsa_pkg::ST_OK;
      res_slot_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= dsa_pkg::ST_OK;
      out_slot_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            res_slot_q   <= '0;
            target_q     <= job_i.deadline;
            idx_q        <= '0;
            second_q     <= 1'b0;
            prev_valid_q <= 1'b0;
            next_valid_q <= 1'b0;
            if (job_i.first) begin
              count_q <= '0;
            end
            if (failed_q && !job_i.first) begin
              res_status_q <= dsa_pkg::ST_FAILED;
              state_q      <= B_RESULT;
            end else if (job_i.over) begin
              res_status_q <= dsa_pkg::ST_OVER;
              failed_q     <= 1'b1;
              state_q      <= B_RESULT;
            end else begin
              res_status_q <= dsa_pkg::ST_OK;
              failed_q     <= 1'b0;
              state_q      <= B_SCAN;
            end
          end
        end
        B_SCAN: begin
          if (idx_q == count_q) begin
            next_valid_q <= 1'b0;
            state_q      <= B_DECIDE;
          end else begin
            state_q <= B_CMP;
          end
        end
        B_CMP: begin
          if (ram_rdata.istart > target_q) begin
            next_q       <= ram_rdata;
            next_valid_q <= 1'b1;
            state_q      <= B_DECIDE;
          end else begin
            prev_q       <= ram_rdata;
            prev_valid_q <= 1'b1;
            idx_q        <= idx_q + CW'(1);
            state_q      <= B_SCAN;
          end
        end
        B_DECIDE: begin
          if (!second_q && covered) begin
            if (prev_q.istart == '0) begin
              res_status_q <= dsa_pkg::ST_NO_SLOT;
              failed_q     <= 1'b1;
              state_q      <= B_RESULT;
            end else begin
              // Retry just below the covering interval; that slot is free.
              target_q     <= prev_q.istart - SW'(1);
              second_q     <= 1'b1;
              idx_q        <= '0;
              prev_valid_q <= 1'b0;
              next_valid_q <= 1'b0;
              state_q      <= B_SCAN;
            end
          end else begin
            if (left && right) begin
              res_slot_q <= target_q;
              j_q        <= idx_q;
              state_q    <= B_SD_RD;
            end else if (left || right) begin
              res_slot_q <= target_q;
              state_q    <= B_RESULT;
            end else if (count_q == CW'(dsa_pkg::MAX_INTERVALS)) begin
              res_status_q <= dsa_pkg::ST_FULL;
              failed_q     <= 1'b1;
              state_q      <= B_RESULT;
            end else begin
              res_slot_q <= target_q;
              j_q        <= count_q;
              state_q    <= B_SU_RD;
            end
          end
        end
        B_SD_RD: begin
          if ({1'b0, j_q} + (CW+1)'(1) >= {1'b0, count_q}) begin
            count_q <= count_q - CW'(1);
            state_q <= B_RESULT;
          end else begin
            state_q <= B_SD_WR;
          end
        end
        B_SD_WR: begin
          j_q     <= j_q + CW'(1);
          state_q <= B_SD_RD;
        end
        B_SU_RD: begin
          if (j_q == idx_q) begin
            count_q <= count_q + CW'(1);
            state_q <= B_RESULT;
          end else begin
            state_q <= B_SU_WR;
          end
        end
        B_SU_WR: begin
          j_q     <= j_q - CW'(1);
          state_q <= B_SU_RD;
        end
        B_RESULT: begin
          if (out_load) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= res_slot_q;
            state_q      <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

@@ sv/deadline_slot_allocator.sv @@
`timescale 1ns / 1ps
// Deadline slot allocator.
// Input channel (s_axis): one item per handshake; tuser carries first_of_run,
// tdata carries height and speed. Output channel (m_axis): one result item
// per input item, in order; tuser carries status, tdata the assigned slot.
// limit is written through limit_we_i / limit_wdata_i; the user must write it
// only while the block is idle, which the block itself does not enforce.
// The front accepts an item, checks height against limit and divides
// (limit - height) by speed with a restoring divider, one bit per cycle;
// the divide is skipped when height is over limit. A two-entry queue then
// hands the item to the back, which walks the interval table in a RAM with
// separate read and write ports and a registered read: it searches the
// stored entries (twice when the deadline is covered) and moves entries on
// an insert or a merge. After a failure, later items of the run skip the
// search until the next first_of_run. A result waits in the output register
// while the receiver stalls; the back holds its next result, and the front
// keeps accepting until the queue fills. Reset clears limit, the interval
// count and the sticky failure; the table itself needs no clearing pass,
// since only entries below the count are ever used.
module deadline_slot_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          limit_we_i,
  input  logic [dsa_pkg::LIMIT_W-1:0]   limit_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // height[31:0], speed[63:32]
  input  logic                          s_axis_tuser,  // first_of_run
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,  // slot[39:0]
  output logic [dsa_pkg::STATUS_W-1:0]  m_axis_tuser   // status[2:0]
);

  logic [dsa_pkg::LIMIT_W-1:0] limit_q;
  logic                        fq_valid;
  logic                        fq_ready;
  dsa_pkg::job_t               fq_job;
  logic                        qb_valid;
  logic                        qb_ready;
  dsa_pkg::job_t               qb_job;

  // Hold the ceiling register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (limit_we_i) begin
      limit_q <= limit_wdata_i;
    end
  end

  // Front: accept, range check, divide.
  dsa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .first_i    (s_axis_tuser),
    .height_i   (s_axis_tdata[31:0]),
    .speed_i    (s_axis_tdata[63:32]),
    .job_valid_o(fq_valid),
    .job_ready_i(fq_ready),
    .job_o      (fq_job)
  );

  // Decouple front and back.
  dsa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_job_i  (fq_job),
    .pop_valid_o (qb_valid),
    .pop_ready_i (qb_ready),
    .pop_job_o   (qb_job)
  );

  // Back: search the table, take a slot, merge intervals.
  dsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(m_axis_tuser),
    .out_slot_o  (m_axis_tdata)
  );

  // A failed result never carries a slot.
  a_slot_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != dsa_pkg::ST_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero slot on failed result");

  // Hold a stalled result unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Status stays within the defined codes.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= dsa_pkg::ST_FULL))
    else $error("undefined status code");

endmodule
